// ===== rtl/hot_zone_visit_tracker_top_defines.svh =====
// Assertion macros for the visit tracker checker.
// No dependencies.
`ifndef HOT_ZONE_VISIT_TRACKER_TOP_DEFINES_SVH
`define HOT_ZONE_VISIT_TRACKER_TOP_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define HZV_ASSERT_IMP(lbl, c, a, e) \
  lbl: assert property (@(posedge c) disable iff (!rst_n) (a)) else $error(e);
// Assert that a condition implies a consequence in the next cycle.
`define HZV_ASSERT_NXT(lbl, c, p, q, e) \
  lbl: assert property (@(posedge c) disable iff (!rst_n) (p) |=> (q)) else $error(e);
`endif

// ===== rtl/hzvt_pkg.sv =====
// Types and constants for the visit tracker.
// No dependencies.
package hzvt_pkg;
  localparam int ZONE_W = 32;
  localparam int DEV_W = 4;
  localparam int SLOT_W = 9;
  localparam int CNT_W = 4;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_DEV = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PARITY_DEV = 2'd3;
  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic [31:0] page_number;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic hit;
    logic claimed;
    logic no_slot;
    logic promote;
    logic [ZONE_W-1:0] zone;
    logic [DEV_W-1:0] brother_device;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_DIV, ST_HREAD, ST_HCHK, ST_HWR,
    ST_SSTEP, ST_SCHK, ST_CWR, ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic clr_step;
    logic load;
    logic div_step;
    logic hit_rd;
    logic hit_adv;
    logic hit_wr;
    logic scan_rd;
    logic scan_adv;
    logic claim_wr;
    logic finish_hit;
    logic finish_miss;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_last;
    logic div_done;
    logic hit_match;
    logic hit_last;
    logic scan_match;
    logic scan_pass_end;
    logic scan_all_end;
  } sts_t;
endpackage

// ===== rtl/hot_zone_visit_tracker_top.sv =====
// Sequence: after accept the zone is divided out, then slots 0..s are read in turn until a hit at slot s;
// a miss then scans the slots round-robin in up to threshold passes before giving no slot.
// Throughput: one item at a time; the next is taken in the cycle after the strobe.
// The zone comes from a bit-serial divider; the single read port sets the scan rate.
// Reset: a clearing pass writes 2^(slot bits + device bits) entries (8192 by
// default) with busy high; configuration returns to its reset values.
module hot_zone_visit_tracker_top #(
  parameter int TABLE_SLOTS = 512,
  parameter int DEVICES = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  hzvt_pkg::in_item_t in_item,
  output logic out_valid,
  output hzvt_pkg::out_item_t out_item,
  input  logic cfg_we,
  input  logic [hzvt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hzvt_pkg::CFG_W-1:0] cfg_data
);
  import hzvt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hzvt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  hzvt_datapath #(.TABLE_SLOTS(TABLE_SLOTS), .DEVICES(DEVICES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_item(in_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_item(out_item)
  );
endmodule

// ===== rtl/hzvt_ctrl.sv =====
// Controller state machine for the visit tracker.
// Depends on hzvt_pkg.
module hzvt_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  hzvt_pkg::sts_t sts,
  output hzvt_pkg::cmd_t cmd
);
  import hzvt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_nxt = ST_HREAD;
      end
      ST_HREAD: begin
        cmd.hit_rd = 1'b1;
        state_nxt = ST_HCHK;
      end
      ST_HCHK: begin
        if (sts.hit_match) state_nxt = ST_HWR;
        else if (sts.hit_last) state_nxt = ST_SSTEP;
        else begin
          cmd.hit_adv = 1'b1;
          state_nxt = ST_HREAD;
        end
      end
      ST_HWR: begin
        cmd.hit_wr = 1'b1;
        cmd.finish_hit = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_SSTEP: begin
        if (sts.scan_all_end) begin
          cmd.finish_miss = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt = ST_SCHK;
        end
      end
      ST_SCHK: begin
        if (sts.scan_match) state_nxt = ST_CWR;
        else begin
          cmd.scan_adv = 1'b1;
          state_nxt = ST_SSTEP;
        end
      end
      ST_CWR: begin
        cmd.claim_wr = 1'b1;
        cmd.finish_miss = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ===== rtl/hzvt_datapath.sv =====
// Datapath: zone divider, per-device entry memory, scan pointers, result register.
// Depends on hzvt_pkg.
module hzvt_datapath #(
  parameter int TABLE_SLOTS = 512,
  parameter int DEVICES = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  hzvt_pkg::cmd_t cmd,
  output hzvt_pkg::sts_t sts,
  input  hzvt_pkg::in_item_t in_item,
  input  logic cfg_we,
  input  logic [hzvt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hzvt_pkg::CFG_W-1:0] cfg_data,
  output logic out_valid,
  output hzvt_pkg::out_item_t out_item
);
  import hzvt_pkg::*;

  localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int AW = SW + DW;
  // Address is {device, slot}, so cover the full concatenated range.
  localparam int DEPTH = 1 << AW;
  localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam int ENT_W = 1 + CNT_W + ZONE_W;

  // Configuration.
  logic [15:0] zsize_r;
  logic [CNT_W-1:0] thr_r;
  logic [3:0] ddev_r;
  logic [2:0] pdev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zsize_r <= 16'd64;
      thr_r <= 4'd10;
      ddev_r <= 4'd4;
      pdev_r <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ZONE_SIZE: zsize_r <= cfg_data;
        CFG_THRESHOLD: thr_r <= cfg_data[CNT_W-1:0];
        CFG_DATA_DEV: ddev_r <= cfg_data[3:0];
        CFG_PARITY_DEV: pdev_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Entry memory: {valid, count, zone}.
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_r;
  logic mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [ENT_W-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[mem_ra];
  end

  logic [AW-1:0] clr_r;
  logic [DEV_W-1:0] devf_r;
  logic [DW-1:0] dev_r;
  logic [DEV_W-1:0] devin_r;
  logic [31:0] rem_r, quo_r;
  logic [5:0] dcnt_r;
  logic [SW-1:0] idx_r;
  logic [SW-1:0] sptr_r [DEVICES];
  logic [SW-1:0] sp_cur;
  logic [SW-1:0] sp_next;
  logic [CNT_W-1:0] pass_r;
  logic [SW-1:0] kcnt_r;
  logic rd_valid;
  logic [CNT_W-1:0] rd_cnt;
  logic [ZONE_W-1:0] rd_zone;
  logic [CNT_W-1:0] inc_cnt;

  // Brother device: the remainder by the parity count is reduced during the divide.
  logic [4:0] bmod_r;
  logic bge_r;
  logic [3:0] dd;
  logic [2:0] pp;
  logic [4:0] dp1_in, offs_in;
  logic [3:0] brother;

  assign dd = (ddev_r == '0) ? 4'd1 : ddev_r;
  assign pp = (pdev_r == '0) ? 3'd1 : pdev_r;
  assign dp1_in = {1'b0, in_item.device} + 5'd1;
  assign offs_in = dp1_in - {1'b0, dd};
  // Below the data count the sum is already smaller than dd, so no reduction is needed.
  assign brother = bge_r ? 4'(bmod_r + {1'b0, dd}) : devin_r + 4'd1;

  assign dev_r = devf_r[DW-1:0];
  assign rd_valid = rd_r[ENT_W-1];
  assign rd_cnt = rd_r[ENT_W-2 -: CNT_W];
  assign rd_zone = rd_r[ZONE_W-1:0];
  assign inc_cnt = (rd_cnt < CNT_MAX) ? rd_cnt + 1'b1 : rd_cnt;
  assign sp_cur = sptr_r[dev_r];
  assign sp_next = (sp_cur == LAST_SLOT) ? '0 : sp_cur + 1'b1;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = {dev_r, idx_r};
    mem_wd = '0;
    mem_ra = {dev_r, idx_r};
    if (cmd.clr_step) begin
      mem_we = 1'b1;
      mem_wa = clr_r;
    end else if (cmd.hit_wr) begin
      mem_we = 1'b1;
      mem_wd = (inc_cnt >= thr_r) ? '0 : {1'b1, inc_cnt, quo_r};
    end else if (cmd.claim_wr) begin
      mem_we = 1'b1;
      mem_wa = {dev_r, sp_cur};
      mem_wd = {1'b1, CNT_W'(1), quo_r};
    end
    if (cmd.scan_rd) mem_ra = {dev_r, sp_next};
  end

  // Restoring divider: one quotient bit a cycle.
  logic [16:0] trial;
  logic [15:0] divisor;
  assign divisor = (zsize_r == '0) ? 16'd1 : zsize_r;
  assign trial = {rem_r[15:0], quo_r[31]} - {1'b0, divisor};

  logic match_now;
  assign match_now = (pass_r == '0) ? !rd_valid : (rd_valid && rd_cnt == pass_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      out_valid <= 1'b0;
      for (int d = 0; d < DEVICES; d++) sptr_r[d] <= '0;
    end else begin
      out_valid <= cmd.finish_hit | cmd.finish_miss;
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.scan_rd) sptr_r[dev_r] <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      devin_r <= in_item.device;
      devf_r <= in_item.device;
      bmod_r <= offs_in;
      bge_r <= (dp1_in >= {1'b0, dd});
      quo_r <= in_item.page_number;
      rem_r <= '0;
      dcnt_r <= '0;
      idx_r <= '0;
      pass_r <= '0;
      kcnt_r <= '0;
    end
    if (cmd.div_step) begin
      if (!trial[16]) rem_r <= {16'd0, trial[15:0]};
      else rem_r <= {rem_r[30:0], quo_r[31]};
      quo_r <= {quo_r[30:0], !trial[16]};
      dcnt_r <= dcnt_r + 1'b1;
      // Fold the device onto the tables and reduce the brother offset, one step a cycle.
      if ({1'b0, devf_r} >= 5'(DEVICES)) devf_r <= devf_r - DEV_W'(DEVICES);
      if (bge_r && bmod_r >= {2'b0, pp}) bmod_r <= bmod_r - {2'b0, pp};
    end
    if (cmd.hit_adv) idx_r <= idx_r + 1'b1;
    if (cmd.scan_adv) begin
      if (kcnt_r == SW'(TABLE_SLOTS - 2)) begin
        kcnt_r <= '0;
        pass_r <= pass_r + 1'b1;
      end else kcnt_r <= kcnt_r + 1'b1;
    end
    if (cmd.finish_hit || cmd.finish_miss) begin
      out_item.zone <= quo_r;
      out_item.hit <= cmd.finish_hit;
      out_item.promote <= cmd.finish_hit && (inc_cnt >= thr_r);
      out_item.claimed <= cmd.claim_wr;
      out_item.no_slot <= cmd.finish_miss && !cmd.claim_wr;
      out_item.slot <= SLOT_W'(cmd.finish_hit ? idx_r : (cmd.claim_wr ? sp_cur : '0));
      out_item.brother_device <= brother;
    end
  end

  assign sts.clr_last = (clr_r == LAST_ADDR);
  assign sts.div_done = (dcnt_r == 6'd31);
  assign sts.hit_match = rd_valid && (rd_zone == quo_r);
  assign sts.hit_last = (idx_r == LAST_SLOT);
  assign sts.scan_match = match_now;
  assign sts.scan_pass_end = (kcnt_r == SW'(TABLE_SLOTS - 2));
  assign sts.scan_all_end = (pass_r >= thr_r);
endmodule

// ===== rtl/hzvt_checker.sv =====
// Port-level checker for the visit tracker, bound to the top level.
// Depends on hzvt_pkg and the defines header.
`include "hot_zone_visit_tracker_top_defines.svh"
module hzvt_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input hzvt_pkg::out_item_t out_item
);
  import hzvt_pkg::*;
  `HZV_ASSERT_IMP(a_one_kind, clk, out_valid |-> $onehot({out_item.hit, out_item.claimed, out_item.no_slot}), "result kind not one-hot")
  `HZV_ASSERT_IMP(a_promote_hit, clk, out_item.promote && out_valid |-> out_item.hit, "promote without hit")
  `HZV_ASSERT_NXT(a_accept_busy, clk, start && !busy, busy, "busy not raised on accept")
  `HZV_ASSERT_NXT(a_single, clk, out_valid, !out_valid, "result repeated")
endmodule

bind hot_zone_visit_tracker_top hzvt_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);

// ===== bench/hot_zone_visit_tracker_checker.sv =====
// Checker for the hot zone visit tracker: snoops the request, result and register ports,
// predicts each result from its own copy of the visit tables and compares field by field.
// Depends on hzvt_pkg.
`timescale 1ns / 1ps
module hot_zone_visit_tracker_checker
  import hzvt_pkg::*;
#(
  parameter int TABLE_SLOTS = 512,
  parameter int DEVICES = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_item_t in_item,
  input  logic out_valid,
  input  out_item_t out_item,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int errors,
  output int pending
);
  logic [ZONE_W-1:0] zone_tab [DEVICES][TABLE_SLOTS];
  logic [CNT_W-1:0] count_tab [DEVICES][TABLE_SLOTS];
  logic valid_tab [DEVICES][TABLE_SLOTS];
  int unsigned rr_ptr [DEVICES];
  logic [15:0] zone_size;
  logic [3:0] threshold;
  logic [3:0] data_devs;
  logic [2:0] parity_devs;
  out_item_t expected_visits[$];

  function automatic logic [DEV_W-1:0] brother_of(logic [DEV_W-1:0] dev);
    int unsigned d, p, b;
    d = (data_devs == 0) ? 1 : data_devs;
    p = (parity_devs == 0) ? 1 : parity_devs;
    if (dev + 1 >= d) b = (dev + 1 - d) % p + d;
    else b = (dev + 1) % d;
    return b[DEV_W-1:0];
  endfunction

  // Update the tables for one request and return the result it should give.
  function automatic out_item_t visit(in_item_t req);
    out_item_t r;
    int unsigned dev, zsz, p;
    logic [ZONE_W-1:0] zone;
    bit found, match;
    dev = req.device % DEVICES;
    zsz = (zone_size == 0) ? 1 : zone_size;
    zone = req.page_number / zsz;
    r = '0;
    r.zone = zone;
    r.brother_device = brother_of(req.device);
    found = 0;
    for (int i = 0; i < TABLE_SLOTS && !found; i++) begin
      if (valid_tab[dev][i] && zone_tab[dev][i] == zone) begin
        if (count_tab[dev][i] != CNT_MAX) count_tab[dev][i]++;
        if (count_tab[dev][i] >= threshold) begin
          r.promote = 1;
          zone_tab[dev][i] = '0;
          count_tab[dev][i] = '0;
          valid_tab[dev][i] = 0;
        end
        r.hit = 1;
        r.slot = i[SLOT_W-1:0];
        found = 1;
      end
    end
    for (int j = 0; !found && j < threshold; j++) begin
      for (int k = 1; k < TABLE_SLOTS && !found; k++) begin
        p = (rr_ptr[dev] + 1) % TABLE_SLOTS;
        rr_ptr[dev] = p;
        if (j == 0) match = !valid_tab[dev][p];
        else match = valid_tab[dev][p] && count_tab[dev][p] == j;
        if (match) begin
          zone_tab[dev][p] = zone;
          count_tab[dev][p] = 1;
          valid_tab[dev][p] = 1;
          r.claimed = 1;
          r.slot = p[SLOT_W-1:0];
          found = 1;
        end
      end
    end
    if (!found) r.no_slot = 1;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int d = 0; d < DEVICES; d++) begin
        rr_ptr[d] = 0;
        for (int s = 0; s < TABLE_SLOTS; s++) begin
          zone_tab[d][s] = '0;
          count_tab[d][s] = '0;
          valid_tab[d][s] = 0;
        end
      end
      zone_size = 16'd64;
      threshold = 4'd10;
      data_devs = 4'd4;
      parity_devs = 3'd1;
      expected_visits.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ZONE_SIZE:  zone_size = cfg_data;
          CFG_THRESHOLD:  threshold = cfg_data[3:0];
          CFG_DATA_DEV:   data_devs = cfg_data[3:0];
          CFG_PARITY_DEV: parity_devs = cfg_data[2:0];
          default: ;
        endcase
      end
      if (start && !busy) expected_visits.push_back(visit(in_item));
      if (out_valid) begin
        if (expected_visits.size() == 0) begin
          $error("result with no request waiting");
          errors++;
        end else begin
          want = expected_visits.pop_front();
          if (out_item.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_item.slot); errors++;
          end
          if (out_item.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_item.hit); errors++;
          end
          if (out_item.claimed !== want.claimed) begin
            $error("claimed: expected %0d, got %0d", want.claimed, out_item.claimed);
            errors++;
          end
          if (out_item.no_slot !== want.no_slot) begin
            $error("no_slot: expected %0d, got %0d", want.no_slot, out_item.no_slot);
            errors++;
          end
          if (out_item.promote !== want.promote) begin
            $error("promote: expected %0d, got %0d", want.promote, out_item.promote);
            errors++;
          end
          if (out_item.zone !== want.zone) begin
            $error("zone: expected %0h, got %0h", want.zone, out_item.zone); errors++;
          end
          if (out_item.brother_device !== want.brother_device) begin
            $error("brother_device: expected %0d, got %0d",
                   want.brother_device, out_item.brother_device);
            errors++;
          end
        end
      end
    end
    pending <= expected_visits.size();
  end

  initial begin
    errors = 0;
    pending = 0;
  end
endmodule

// ===== bench/hot_zone_visit_tracker_top_test.sv =====
// Testbench top for the hot zone visit tracker: drives requests and register writes,
// gives the verdict. Depends on hzvt_pkg, hot_zone_visit_tracker_top and the checker.
`timescale 1ns / 1ps
module hot_zone_visit_tracker_top_test;
  import hzvt_pkg::*;

  localparam int STALL_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_item;
  logic out_valid;
  out_item_t out_item;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int errors;
  int pending;
  int stall_cycles;
  bit gaps_on;
  logic [15:0] cur_zone_size;
  logic [ZONE_W-1:0] zone_pool [8];

  hot_zone_visit_tracker_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  hot_zone_visit_tracker_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Watchdog: count cycles in which no item moves on either side.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Leaves start high so back-to-back items need no second assignment.
  task automatic send(logic [DEV_W-1:0] dev, logic [31:0] page);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    start <= 1;
    in_item <= '{device: dev, page_number: page};
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    if (idx == CFG_ZONE_SIZE) cur_zone_size = val;
  endtask

  task automatic set_all(logic [15:0] zs, logic [3:0] thr, logic [3:0] dd, logic [2:0] pd);
    drain();
    write_reg(CFG_ZONE_SIZE, zs);
    write_reg(CFG_THRESHOLD, 16'(thr));
    write_reg(CFG_DATA_DEV, 16'(dd));
    write_reg(CFG_PARITY_DEV, 16'(pd));
  endtask

  // Mostly pages that land in a small set of zones, so hits and promotes happen.
  task automatic random_phase(int count);
    logic [31:0] zs, page;
    zs = (cur_zone_size == 0) ? 1 : 32'(cur_zone_size);
    foreach (zone_pool[i]) zone_pool[i] = $urandom_range(0, 3) == 0 ? $urandom() / zs
                                                                    : $urandom_range(0, 20);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 4) == 0) page = $urandom();
      else page = zone_pool[$urandom_range(0, 7)] * zs + $urandom_range(0, zs - 1);
      send(4'($urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(0, 3)),
           page);
      if (n % 50 == 49) gaps_on = ($urandom_range(0, 2) != 0) && gaps_on;
    end
  endtask

  initial begin
    rst_n = 0;
    start = 0;
    in_item = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    stall_cycles = 0;
    cur_zone_size = 16'd64;
    gaps_on = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // Claim, climb to the reset threshold and promote.
    repeat (10) send(4'd0, 32'd5);
    send(4'd15, 32'hFFFF_FFFF);
    send(4'd3, 32'h8000_0000);
    send(4'd2, 32'd63);
    send(4'd2, 32'd64);

    // Zero zone size acts as one; zero device counts act as one; threshold zero.
    set_all(16'd0, 4'd0, 4'd0, 3'd0);
    send(4'd7, 32'h1234_5678);
    send(4'd0, 32'd5);
    // Stale count: build up under a high threshold, then lower it.
    set_all(16'hFFFF, 4'd15, 4'd15, 3'd7);
    repeat (5) send(4'd9, 32'hFFFF_0000);
    send(4'd14, 32'd0);
    set_all(16'hFFFF, 4'd3, 4'd1, 3'd4);
    send(4'd9, 32'hFFFF_0001);
    send(4'd0, 32'd1);
    // Threshold one: misses only take empty slots, every hit promotes.
    set_all(16'd1, 4'd1, 4'd8, 3'd2);
    send(4'd4, 32'd100);
    send(4'd4, 32'd100);

    set_all(16'd64, 4'd10, 4'd4, 3'd1);
    random_phase(150);
    set_all(16'd1, 4'd2, 4'd15, 3'd4);
    random_phase(150);
    set_all(16'hFFFF, 4'd15, 4'd1, 3'd1);
    random_phase(150);
    drain();
    write_reg(CFG_THRESHOLD, 16'd0);
    random_phase(80);
    set_all(16'($urandom_range(1, 1000)), 4'($urandom_range(1, 15)), 4'($urandom()),
            3'($urandom()));
    random_phase(200);
    set_all(16'd0, 4'd1, 4'd0, 3'd0);
    random_phase(120);
    set_all(16'($urandom()), 4'($urandom_range(2, 15)), 4'($urandom()), 3'($urandom()));
    random_phase(200);
    // Last part: no gaps from the sender.
    gaps_on = 0;
    set_all(16'd8, 4'd5, 4'd6, 3'd3);
    random_phase(200);

    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
